FILE: design/adge_pkg.sv
// ============================================================================
// Audio ducking gain envelope - shared package
// Widths, constants, types and the constant table of fractional roots of two
// that the gain envelope, its dB-to-linear unit and its channel lanes share.
// ============================================================================
package adge_pkg;

  // Block dimensions
  localparam int LANES            = 8;
  localparam int SAMPLE_BITS      = 24;
  localparam int MAX_BLOCK_FRAMES = 4096;

  // Frame position and block length widths
  localparam int POS_W = $clog2(MAX_BLOCK_FRAMES);
  localparam int FPB_W = 13;
  localparam int LANE_W = $clog2(LANES + 1);

  // Interpolation divider: the quotient never exceeds the duck depth
  localparam int QUOT_W = 16;
  localparam int DEN_W  = POS_W + 1;
  localparam int NUM_W  = QUOT_W + POS_W;

  // Linear gain factor in Q30, one integer bit so that unity fits
  localparam int LIN_FRAC   = 30;
  localparam int LIN_W      = LIN_FRAC + 1;
  localparam int ROOT_STEPS = 16;

  // Attenuation magnitude in Q8.8 dB and the log2(10)/20 factor in Q24
  localparam int E_W       = 15;
  localparam int LOG_W     = 22;
  localparam int LOG_CONST = 2786635;

  // Register limits
  localparam int DEPTH_MAX = 24576;
  localparam int COEF_ONE  = 65536;

  // Stream word width: all lanes packed, rounded up to whole bytes
  localparam int TDATA_W = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LIN_W-1:0]              lin_t;
  typedef logic signed [15:0]            gain_t;
  typedef logic [ROOT_STEPS-1:0][LIN_FRAC-1:0] root_tab_t;

  // Integer square root, digit by digit, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    xx = x;
    for (int i = 0; i < 32; i++) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^(-2^-(k+1)) in Q30, each one the floor square root of the last.
  function automatic root_tab_t build_roots();
    logic [63:0] v;
    root_tab_t   t;
    v = 64'd1 << (LIN_FRAC - 1);
    for (int k = 0; k < ROOT_STEPS; k++) begin
      v    = isqrt64(v << LIN_FRAC);
      t[k] = v[LIN_FRAC-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

FILE: design/adge_div.sv
// ============================================================================
// Interpolation divider
// Restoring unsigned divider that produces one quotient bit per cycle. It
// returns the quotient and whether a remainder was left, for floor rounding.
// ============================================================================
module adge_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [adge_pkg::NUM_W-1:0] num_i,
  input  logic [adge_pkg::DEN_W-1:0] den_i,
  output logic                       done_o,
  output logic [adge_pkg::QUOT_W-1:0] quot_o,
  output logic                       rem_nz_o
);
  import adge_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_r;
  logic [QUOT_W-1:0] quot_r;
  logic              fits;

  assign fits = (rem_r >= dsh_r);

  // Step control: a fixed number of steps, one quotient bit each
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare the remainder with the shifted divisor and subtract
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r  <= num_i;
      dsh_r  <= NUM_W'({den_i, {(QUOT_W-1){1'b0}}});
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[QUOT_W-2:0], fits};
      dsh_r  <= dsh_r >> 1;
    end
  end

  assign done_o   = done_r;
  assign quot_o   = quot_r;
  assign rem_nz_o = (rem_r != '0);

endmodule

FILE: design/adge_db2lin.sv
// ============================================================================
// dB to linear converter
// Turns an attenuation in Q8.8 dB into a Q30 linear factor: a base-2
// exponent by one multiplication, then the fractional part as a product of
// tabled roots of two, one per cycle, and a rounded shift for the integer part.
// ============================================================================
module adge_db2lin (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic [adge_pkg::E_W-1:0] e_i,
  output logic                     done_o,
  output adge_pkg::lin_t           lin_o
);
  import adge_pkg::*;

  localparam int XP_W   = E_W + LOG_W;
  localparam int STEP_W = $clog2(ROOT_STEPS);
  localparam int N_W    = XP_W - 32;
  localparam int PR_W   = LIN_W + LIN_FRAC;

  logic              busy_r;
  logic              shift_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [N_W-1:0]    n_r;
  logic [ROOT_STEPS-1:0] f_r;
  lin_t              acc_r;
  lin_t              lin_r;

  logic [XP_W-1:0]   xp;
  logic [PR_W-1:0]   prod;
  logic [PR_W-1:0]   prnd;
  lin_t              acc_nxt;
  logic [LIN_W:0]    ssum;
  lin_t              lin_nxt;

  // Base-2 exponent in Q16, rounded half up
  assign xp = XP_W'(e_i) * XP_W'(LOG_CONST) + XP_W'(32768);

  // One root factor per cycle, rounded back to Q30
  assign prod    = PR_W'(acc_r) * PR_W'(ROOT_TAB[step_r]);
  assign prnd    = prod + (PR_W'(1) << (LIN_FRAC - 1));
  assign acc_nxt = prnd[PR_W-1:LIN_FRAC];

  // Rounded right shift by the integer part of the exponent
  always_comb begin
    ssum = {1'b0, acc_r} + ((LIN_W + 1)'(1) << (n_r - N_W'(1)));
    if (n_r == '0) begin
      lin_nxt = acc_r;
    end else begin
      lin_nxt = LIN_W'(ssum >> n_r);
    end
  end

  // Sequencing: exponent, root steps, final shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      shift_r <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          busy_r  <= 1'b0;
          shift_r <= 1'b1;
        end
      end else if (shift_r) begin
        shift_r <= 1'b0;
        done_r  <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start_i) begin
      n_r   <= xp[XP_W-1:32];
      f_r   <= xp[31:16];
      acc_r <= LIN_W'(1) << LIN_FRAC;
    end else if (busy_r) begin
      if (f_r[ROOT_STEPS-1]) begin
        acc_r <= acc_nxt;
      end
      f_r <= f_r << 1;
    end
    if (shift_r) begin
      lin_r <= lin_nxt;
    end
  end

  assign done_o = done_r;
  assign lin_o  = lin_r;

endmodule

FILE: design/adge_lane.sv
// ============================================================================
// Channel lane
// Multiplies one channel sample by the linear gain factor and rounds the
// result back to the sample format. A lane beyond the channel count gives zero.
// ============================================================================
module adge_lane (
  input  logic              clk,
  input  logic              load_i,
  input  logic              en_i,
  input  adge_pkg::sample_t sample_i,
  input  adge_pkg::lin_t    lin_i,
  output adge_pkg::sample_t res_o
);
  import adge_pkg::*;

  localparam int PR_W = SAMPLE_BITS + LIN_W + 1;

  logic signed [PR_W-1:0] prod;
  logic signed [PR_W-1:0] prnd;
  sample_t                res_r;

  // Signed product, rounded half up at the Q30 point
  assign prod = sample_i * $signed({1'b0, lin_i});
  assign prnd = prod + (PR_W'(1) <<< (LIN_FRAC - 1));

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= en_i ? prnd[LIN_FRAC+SAMPLE_BITS-1:LIN_FRAC] : '0;
    end
  end

  assign res_o = res_r;

endmodule

FILE: design/audio_ducking_gain_envelope.sv
// ============================================================================
// Audio ducking gain envelope
// Attack / hold / release ducker over blocks of multichannel frames. Each
// input word carries one frame of up to eight 24-bit Q1.23 samples and the
// duck key in tuser; each output word carries the ducked frame, with tlast
// marking the last frame of a block. On the first frame of a block the key is
// sampled and the dB gain takes one one-pole step, toward minus the depth with
// the attack factor while the key is set or hold blocks remain, else toward
// 0 dB with the release factor. Inside the block the gain is interpolated
// linearly in dB, converted to a linear factor and applied to every active
// channel. One frame is in work at a time: the next is accepted only once
// this one has passed the bit-serial interpolation divider and the
// dB-to-linear unit, whose single multiplier walks the 16 fractional root
// factors, and has gone to the output register. A finished frame waits in
// the output register while the next frame is accepted.
// Registers sit on the APB port at byte address 4*i: depth, attack factor,
// release factor, hold blocks, frames per block, channels in use. Write them
// only while no frame is in work.
// ============================================================================
module audio_ducking_gain_envelope (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input frames
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [adge_pkg::TDATA_W-1:0] in_tdata,  // sample_0 .. sample_7
  input  logic [0:0]                   in_tuser,  // duck_key
  // Ducked frames
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [adge_pkg::TDATA_W-1:0] out_tdata, // out_0 .. out_7
  output logic                         out_tlast, // block_last
  // Configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [4:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import adge_pkg::*;

  // Register map
  localparam logic [2:0] REG_DEPTH   = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_HOLD    = 3'd3;
  localparam logic [2:0] REG_FPB     = 3'd4;
  localparam logic [2:0] REG_CHAN    = 3'd5;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POLE   = 4'd1;
  localparam logic [3:0] S_NUM    = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_LSTART = 4'd5;
  localparam logic [3:0] S_LWAIT  = 4'd6;
  localparam logic [3:0] S_LANE   = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;

  localparam int NUMS_W = POS_W + 19;

  // Configuration registers
  logic [14:0]      depth_r;
  logic [16:0]      attack_r;
  logic [16:0]      release_r;
  logic [15:0]      hold_cfg_r;
  logic [FPB_W-1:0] fpb_r;
  logic [3:0]       chan_r;
  logic             cfg_wr;

  // Envelope state
  logic [3:0]       state_r;
  logic [3:0]       state_nxt;
  gain_t            gain_r;
  gain_t            start_r;
  logic [15:0]      hold_left_r;
  logic [POS_W-1:0] pos_r;

  // Frame and datapath registers
  sample_t          smp_r [LANES];
  logic             key_r;
  logic [NUM_W-1:0] num_mag_r;
  logic             num_neg_r;
  logic [E_W-1:0]   e_r;

  // Output register
  logic               out_tvalid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic               out_tlast_r;
  logic [TDATA_W-1:0] out_tdata_nxt;

  // Clamped configuration
  logic [14:0]       depth_c;
  logic [16:0]       attack_c;
  logic [16:0]       release_c;
  logic [FPB_W-1:0]  fpb_c;
  logic [LANE_W-1:0] lanes_c;
  logic [POS_W-1:0]  denom;
  logic [POS_W-1:0]  idx;
  logic              last_frame;

  // One-pole step
  logic               use_attack;
  logic signed [16:0] target_s;
  logic signed [16:0] pdiff;
  logic signed [17:0] coef_s;
  logic signed [34:0] pprod;
  logic signed [34:0] prnd;
  logic signed [16:0] pstep;
  logic signed [16:0] gsum;
  logic [15:0]        hold_nxt;

  // Interpolation
  logic signed [16:0]       idiff;
  logic signed [POS_W+1:0]  idx2_s;
  logic signed [NUMS_W-1:0] inum;
  logic signed [NUMS_W-1:0] inum_abs;
  logic [QUOT_W:0]          qadj;
  logic signed [16:0]       goff;
  logic signed [16:0]       gint;
  logic signed [16:0]       gneg;
  logic [E_W-1:0]           e_nxt;

  // Unit links
  logic              div_done;
  logic [QUOT_W-1:0] div_q;
  logic              div_rnz;
  logic              lin_done;
  lin_t              lin;
  sample_t           lane_res [LANES];
  logic              out_free;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      attack_r   <= 17'(COEF_ONE);
      release_r  <= 17'(COEF_ONE);
      hold_cfg_r <= '0;
      fpb_r      <= FPB_W'(1024);
      chan_r     <= 4'd2;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_DEPTH:   depth_r    <= cfg_pwdata[14:0];
        REG_ATTACK:  attack_r   <= cfg_pwdata[16:0];
        REG_RELEASE: release_r  <= cfg_pwdata[16:0];
        REG_HOLD:    hold_cfg_r <= cfg_pwdata[15:0];
        REG_FPB:     fpb_r      <= cfg_pwdata[FPB_W-1:0];
        REG_CHAN:    chan_r     <= cfg_pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_DEPTH:   cfg_prdata = 32'(depth_r);
      REG_ATTACK:  cfg_prdata = 32'(attack_r);
      REG_RELEASE: cfg_prdata = 32'(release_r);
      REG_HOLD:    cfg_prdata = 32'(hold_cfg_r);
      REG_FPB:     cfg_prdata = 32'(fpb_r);
      REG_CHAN:    cfg_prdata = 32'(chan_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // Out-of-range register values are taken at the nearest limit.
  always_comb begin
    depth_c   = (depth_r > 15'(DEPTH_MAX)) ? 15'(DEPTH_MAX) : depth_r;
    attack_c  = (attack_r > 17'(COEF_ONE)) ? 17'(COEF_ONE) : attack_r;
    release_c = (release_r > 17'(COEF_ONE)) ? 17'(COEF_ONE) : release_r;
    if (fpb_r == '0) begin
      fpb_c = FPB_W'(1);
    end else if (fpb_r > FPB_W'(MAX_BLOCK_FRAMES)) begin
      fpb_c = FPB_W'(MAX_BLOCK_FRAMES);
    end else begin
      fpb_c = fpb_r;
    end
    if (chan_r == '0) begin
      lanes_c = LANE_W'(1);
    end else if (chan_r > 4'(LANES)) begin
      lanes_c = LANE_W'(LANES);
    end else begin
      lanes_c = LANE_W'(chan_r);
    end
    denom      = (fpb_c > FPB_W'(1)) ? POS_W'(fpb_c - FPB_W'(1)) : POS_W'(1);
    idx        = (pos_r < denom) ? pos_r : denom;
    last_frame = (FPB_W'(pos_r) + FPB_W'(1)) >= fpb_c;
  end

  // ---------------------------------------------------------------------------
  // One-pole gain step at the start of a block
  // ---------------------------------------------------------------------------
  always_comb begin
    use_attack = key_r | (hold_left_r != '0);
    target_s   = use_attack ? -$signed({2'b00, depth_c}) : '0;
    coef_s     = $signed({1'b0, use_attack ? attack_c : release_c});
    pdiff      = target_s - $signed({gain_r[15], gain_r});
    pprod      = pdiff * coef_s;
    prnd       = pprod + 35'sd32768;
    pstep      = prnd[32:16];
    gsum       = $signed({gain_r[15], gain_r}) + pstep;
    if (key_r) begin
      hold_nxt = hold_cfg_r;
    end else if (hold_left_r != '0) begin
      hold_nxt = hold_left_r - 16'd1;
    end else begin
      hold_nxt = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation numerator and the gain that the divider's quotient gives
  // ---------------------------------------------------------------------------
  always_comb begin
    idiff    = $signed({gain_r[15], gain_r}) - $signed({start_r[15], start_r});
    idx2_s   = $signed({1'b0, idx, 1'b0});
    inum     = idiff * idx2_s + $signed({{(NUMS_W-POS_W){1'b0}}, denom});
    inum_abs = inum[NUMS_W-1] ? -inum : inum;
    // Floor of a negative quotient rounds away from zero when a remainder is left.
    qadj     = {1'b0, div_q} + (QUOT_W+1)'(num_neg_r & div_rnz);
    goff     = num_neg_r ? -$signed(qadj) : $signed(qadj);
    gint     = $signed({start_r[15], start_r}) + goff;
    gneg     = -gint;
    e_nxt    = gint[16] ? gneg[E_W-1:0] : '0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_POLE;
      S_POLE:   state_nxt = S_NUM;
      S_NUM:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT:  if (div_done) state_nxt = S_LSTART;
      S_LSTART: state_nxt = S_LWAIT;
      S_LWAIT:  if (lin_done) state_nxt = S_LANE;
      S_LANE:   state_nxt = S_WRITE;
      S_WRITE:  if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, envelope, block position, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gain_r       <= '0;
      start_r      <= '0;
      hold_left_r  <= '0;
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_POLE && pos_r == '0) begin
        start_r     <= gain_r;
        gain_r      <= gsum[15:0];
        hold_left_r <= hold_nxt;
      end
      if (state_r == S_WRITE && out_free) begin
        out_tvalid_r <= 1'b1;
        pos_r        <= last_frame ? '0 : pos_r + 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Frame capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tuser[0];
      for (int k = 0; k < LANES; k++) begin
        smp_r[k] <= in_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (state_r == S_NUM) begin
      num_mag_r <= inum_abs[NUM_W-1:0];
      num_neg_r <= inum[NUMS_W-1];
    end
    if (state_r == S_DWAIT && div_done) begin
      e_r <= e_nxt;
    end
    if (state_r == S_WRITE && out_free) begin
      out_tdata_r <= out_tdata_nxt;
      out_tlast_r <= last_frame;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  adge_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (state_r == S_DSTART),
    .num_i    (num_mag_r),
    .den_i    ({denom, 1'b0}),
    .done_o   (div_done),
    .quot_o   (div_q),
    .rem_nz_o (div_rnz)
  );

  adge_db2lin u_db2lin (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (state_r == S_LSTART),
    .e_i     (e_r),
    .done_o  (lin_done),
    .lin_o   (lin)
  );

  // ---------------------------------------------------------------------------
  // Channel lanes, all working on the same frame
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    adge_lane u_lane (
      .clk      (clk),
      .load_i   (state_r == S_LANE),
      .en_i     (LANE_W'(k) < lanes_c),
      .sample_i (smp_r[k]),
      .lin_i    (lin),
      .res_o    (lane_res[k])
    );
  end

  // Merge the lane results into one output word
  always_comb begin
    out_tdata_nxt = '0;
    for (int k = 0; k < LANES; k++) begin
      out_tdata_nxt[k*SAMPLE_BITS +: SAMPLE_BITS] = lane_res[k];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second frame accepted while one is in work");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_r <= gain_t'(0)) && (gain_r >= -gain_t'(DEPTH_MAX)))
    else $error("gain envelope left the range from minus full depth to 0 dB");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");

  a_lin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lin_done |-> (state_r == S_LWAIT))
    else $error("dB to linear unit finished outside its wait state");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_WRITE))
    else $error("output word appeared without a write step");

endmodule

FILE: tb/sv/audio_ducking_gain_envelope_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Audio ducking gain envelope - self-checking testbench
// Streams multichannel frames into the ducker with random gaps on the input
// side and random back-pressure on the output side. Each accepted frame is run
// through a bit-accurate envelope predictor: one-pole dB step per block, linear
// dB interpolation, fixed-point dB-to-linear conversion and rounded lane gain.
// Every ducked word is compared lane by lane and on tlast with the oldest
// prediction. Registers are rewritten on the APB port between drained phases.
// ============================================================================
module audio_ducking_gain_envelope_test;
  import adge_pkg::*;

  localparam int          DEPTH_LIMIT   = 24576;
  localparam int          COEF_UNITY    = 65536;
  localparam longint      LOG2_10_Q24   = 2786635;
  localparam int          DRAIN_PAUSE   = 60;
  localparam int          RANDOM_PHASES = 12;
  localparam int          PHASE_FRAMES  = 150;

  typedef enum int unsigned {
    REG_DEPTH, REG_ATTACK, REG_RELEASE, REG_HOLD, REG_FPB, REG_LANES
  } reg_idx_e;

  // One input word: duck key and all sample lanes.
  typedef struct packed {
    logic                     key;
    sample_t [LANES-1:0]      smp;
  } frame_t;

  // One ducked word: lane samples and the block end flag.
  typedef struct packed {
    logic                     last;
    sample_t [LANES-1:0]      lane;
  } ducked_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;  // sample_0 .. sample_7
  logic [0:0]         in_tuser = '0;  // duck_key
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;      // out_0 .. out_7
  logic               out_tlast;      // block_last
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [4:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  audio_ducking_gain_envelope uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial forever #4 clk = ~clk;

  // Register copies as written, before any clamping.
  int unsigned reg_depth   = 0;
  int unsigned reg_attack  = COEF_UNITY;
  int unsigned reg_release = COEF_UNITY;
  int unsigned reg_hold    = 0;
  int unsigned reg_fpb     = 1024;
  int unsigned reg_lanes   = 2;

  // Envelope state of the predictor.
  int          gain_db      = 0;
  int          blk_start_db = 0;
  int unsigned hold_cnt     = 0;
  int unsigned frame_pos    = 0;
  longint unsigned root_q30 [16];

  frame_t  pending_frames [$];
  ducked_t ducked_expected [$];
  int      fail_count = 0;
  bit      calm = 1'b0;

  // Floor square root, one result bit at a time.
  function automatic longint unsigned isqrt_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // floor(v / 2^sh + 1/2)
  function automatic longint round_shift_right(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int one_pole(int cur, int target, int unsigned coef);
    longint c;
    c = (coef > COEF_UNITY) ? COEF_UNITY : coef;
    return cur + int'(round_shift_right(longint'(target - cur) * c, 16));
  endfunction

  // 10^(g/20) in Q30 for a Q8.8 dB gain at or below zero.
  function automatic longint unsigned gain_to_linear(int g);
    longint unsigned e, x, n, f, acc;
    e = (g < 0) ? longint'(-g) : 0;
    x = (e * LOG2_10_Q24 + 32768) >> 16;
    n = x >> 16;
    f = x & 64'hFFFF;
    acc = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if (((f >> (15 - k)) & 64'd1) != 0)
        acc = (acc * root_q30[k] + (64'd1 << 29)) >> 30;
    if (n > 40) return 0;
    if (n > 0) acc = (acc + (64'd1 << (n - 1))) >> n;
    return acc;
  endfunction

  // Advances the envelope by one frame and returns the ducked word.
  function automatic ducked_t duck_frame(frame_t f);
    int unsigned     fpb, lanes, denom, idx;
    int              depth_eff, g;
    longint          num, div, q;
    longint unsigned lin;
    ducked_t         r;
    fpb   = (reg_fpb == 0) ? 1 : ((reg_fpb > MAX_BLOCK_FRAMES) ? MAX_BLOCK_FRAMES : reg_fpb);
    lanes = (reg_lanes == 0) ? 1 : ((reg_lanes > LANES) ? LANES : reg_lanes);
    if (frame_pos == 0) begin
      depth_eff    = (reg_depth > DEPTH_LIMIT) ? DEPTH_LIMIT : reg_depth;
      blk_start_db = gain_db;
      if (f.key) begin
        hold_cnt = reg_hold;
        gain_db  = one_pole(gain_db, -depth_eff, reg_attack);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        gain_db = one_pole(gain_db, -depth_eff, reg_attack);
      end else begin
        gain_db = one_pole(gain_db, 0, reg_release);
      end
    end
    // Linear dB interpolation across the block, rounded half up.
    denom = (fpb > 1) ? fpb - 1 : 1;
    idx   = (frame_pos < denom) ? frame_pos : denom;
    num   = longint'(gain_db - blk_start_db) * 2 * longint'(idx) + longint'(denom);
    div   = 2 * longint'(denom);
    q     = num / div;
    if ((num % div != 0) && (num < 0)) q--;
    g   = blk_start_db + int'(q);
    lin = gain_to_linear(g);
    for (int c = 0; c < LANES; c++)
      r.lane[c] = (c < lanes) ?
                  sample_t'(round_shift_right(longint'(f.smp[c]) * longint'(lin), 30)) : '0;
    r.last    = (frame_pos + 1 >= fpb);
    frame_pos = r.last ? 0 : frame_pos + 1;
    return r;
  endfunction

  // Idle lengths: mostly short, now and then long.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic int send_gap();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    return idle_len();
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 15))
      0: return sample_t'(24'h7FFFFF);
      1: return sample_t'(24'h800000);
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame(logic key);
    frame_t f;
    f.key = key;
    for (int c = 0; c < LANES; c++) f.smp[c] = pick_sample();
    return f;
  endfunction

  // Full-scale positive, full-scale negative, zero and minus one across lanes.
  function automatic frame_t corner_frame(logic key, int n);
    frame_t f;
    f.key = key;
    for (int c = 0; c < LANES; c++)
      case ((c + n) % 4)
        0: f.smp[c] = sample_t'(24'h7FFFFF);
        1: f.smp[c] = sample_t'(24'h800000);
        2: f.smp[c] = '0;
        default: f.smp[c] = '1;
      endcase
    return f;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_DEPTH:   reg_depth   = value & 32'h7FFF;
      REG_ATTACK:  reg_attack  = value & 32'h1FFFF;
      REG_RELEASE: reg_release = value & 32'h1FFFF;
      REG_HOLD:    reg_hold    = value & 32'hFFFF;
      REG_FPB:     reg_fpb     = value & 32'h1FFF;
      REG_LANES:   reg_lanes   = value & 32'hF;
      default: ;
    endcase
  endtask

  task automatic write_setting(input int unsigned depth, input int unsigned attack,
                               input int unsigned rel, input int unsigned hold,
                               input int unsigned fpb, input int unsigned lanes);
    write_reg(REG_DEPTH, depth);
    write_reg(REG_ATTACK, attack);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_HOLD, hold);
    write_reg(REG_FPB, fpb);
    write_reg(REG_LANES, lanes);
  endtask

  function automatic int unsigned pick_coef();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return COEF_UNITY;
      2: return $urandom_range(COEF_UNITY + 1, 131071);
      3: return $urandom_range(1, 255);
      default: return $urandom_range(1, COEF_UNITY - 1);
    endcase
  endfunction

  function automatic int unsigned pick_depth();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return DEPTH_LIMIT;
      2: return $urandom_range(DEPTH_LIMIT + 1, 32767);
      default: return $urandom_range(1, DEPTH_LIMIT - 1);
    endcase
  endfunction

  function automatic int unsigned pick_hold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  function automatic int unsigned pick_fpb();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MAX_BLOCK_FRAMES, 8191);
      2: return $urandom_range(13, 300);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Waits until every frame has been sent and every ducked word has come back.
  task automatic drain();
    @(posedge clk);
    while (pending_frames.size() != 0 || in_tvalid || ducked_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Input side: acceptance runs the predictor.
  frame_t cur_frame = '0;
  bit     cur_busy  = 1'b0;
  bit     in_taken  = 1'b0;
  int     in_gap    = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      ducked_expected.push_back(duck_frame(cur_frame));
      in_taken = 1'b1;
    end
  end

  // Input driver: presents the next pending frame after a random gap.
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      cur_busy = 1'b0;
      in_gap   = send_gap();
    end
    if (rst_n && !cur_busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_frames.size() != 0) begin
        cur_frame = pending_frames.pop_front();
        cur_busy  = 1'b1;
      end
    end
    in_tvalid <= cur_busy;
    in_tdata  <= cur_frame.smp;
    in_tuser  <= cur_frame.key;
  end

  // Output back-pressure: random stalls of random length.
  int out_stall = 0;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) out_stall = idle_len();
    end
  end

  // Output monitor: each ducked word against the oldest prediction.
  always @(posedge clk) begin
    ducked_t          want;
    sample_t [LANES-1:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (ducked_expected.size() == 0) begin
        if (fail_count < 10) $display("unexpected ducked word %h", out_tdata);
        fail_count++;
      end else begin
        want = ducked_expected.pop_front();
        for (int c = 0; c < LANES; c++)
          if (got[c] !== want.lane[c]) begin
            if (fail_count < 10)
              $display("lane %0d: expected %h, got %h", c, want.lane[c], got[c]);
            fail_count++;
          end
        if (out_tlast !== want.last) begin
          if (fail_count < 10) $display("tlast: expected %b, got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    logic key;
    int   key_left;
    int   n;
    root_q30[0] = isqrt_floor((64'd1 << 29) << 30);
    for (int k = 1; k < 16; k++) root_q30[k] = isqrt_floor(root_q30[k-1] << 30);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, unity gain on full-scale words; leaves a block unfinished.
    pending_frames.push_back(corner_frame(1'b0, 0));
    pending_frames.push_back(corner_frame(1'b0, 1));
    drain();

    // Single-frame blocks cut the open block short; full depth with jumps and hold.
    write_setting(DEPTH_LIMIT, COEF_UNITY, COEF_UNITY, 2, 1, 8);
    pending_frames.push_back(corner_frame(1'b1, 2));
    pending_frames.push_back(corner_frame(1'b0, 3));
    pending_frames.push_back(corner_frame(1'b0, 0));
    pending_frames.push_back(corner_frame(1'b0, 1));
    pending_frames.push_back(corner_frame(1'b0, 2));
    drain();

    // Registers out of range: depth and attack factor above, zero frames per block and lanes.
    write_setting(32767, 131071, 100, 0, 0, 0);
    pending_frames.push_back(corner_frame(1'b1, 0));
    for (int i = 1; i < 4; i++) pending_frames.push_back(corner_frame(1'b0, i));
    drain();

    // Interpolation over a short block, lanes above range, release frozen.
    write_setting(6000, 20000, 0, 0, 5, 15);
    pending_frames.push_back(corner_frame(1'b1, 0));
    for (int i = 1; i < 10; i++) pending_frames.push_back(corner_frame(1'b0, i));
    drain();

    // Random phases: keyed runs with random content, random settings.
    key      = 1'b0;
    key_left = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      write_setting(pick_depth(), pick_coef(), pick_coef(), pick_hold(), pick_fpb(),
                    $urandom_range(0, 15));
      n = PHASE_FRAMES;
      for (int i = 0; i < n; i++) begin
        if (key_left == 0) begin
          key      = ~key;
          key_left = $urandom_range(1, 40);
        end
        key_left--;
        pending_frames.push_back(random_frame(($urandom_range(0, 15) == 0) ? ~key : key));
      end
      drain();
    end

    if (ducked_expected.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
